@@ hw/rtl/bgi_pkg.sv @@
// Package for the bilinear grid interpolator: sizes, register indexes,
// the transaction and configuration structs, and the saturating helpers.
// No dependencies.
package bgi_pkg;

  localparam int MAX_FIRST_POINTS  = 64;
  localparam int MAX_SECOND_POINTS = 64;
  localparam int ROW_W   = $clog2(MAX_FIRST_POINTS);
  localparam int COL_W   = $clog2(MAX_SECOND_POINTS);
  localparam int IDX_W   = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int PTS_W   = 7;
  localparam int FRAC_W  = 16;
  localparam int BANK_AW = (ROW_W - 1) + (COL_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NUM_BANKS  = 4;

  localparam int MULQ_LAT  = 3;
  localparam int Q_DEPTH   = 8;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int OUT_DEPTH = 16;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ORIGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_INV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_INV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_POINTS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_POINTS = 3'd5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] org1;
    logic signed [31:0] org2;
    logic [31:0]        inv1;
    logic [31:0]        inv2;
    logic [PTS_W-1:0]   pts1;
    logic [PTS_W-1:0]   pts2;
  } cfg_t;

  // Row/col hold the sample position on a load and the cell corner on an eval.
  typedef struct packed {
    logic               eval;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [31:0]        sample;
    logic signed [63:0] t;
    logic signed [63:0] u;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] slope1;
    logic signed [31:0] slope2;
  } result_t;

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (!v[63] && (v[62:31] != 32'h0)) return 32'sh7FFF_FFFF;
    if (v[63] && (v[62:31] != 32'hFFFF_FFFF)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [PTS_W-1:0] clamp_points(input logic [PTS_W-1:0] n,
                                                    input logic [PTS_W-1:0] lim);
    if (n < PTS_W'(2)) return PTS_W'(2);
    if (n > lim) return lim;
    return n;
  endfunction

  // Lower-left index: zero below the grid, capped at points-2 above it.
  function automatic logic [IDX_W-1:0] cell_index(input logic signed [63:0] s,
                                                  input logic [PTS_W-1:0] n);
    logic [PTS_W-1:0] top;
    top = n - PTS_W'(2);
    if (s[63]) return '0;
    if (s[63:FRAC_W] > {{(64-FRAC_W-PTS_W){1'b0}}, top}) return IDX_W'(top);
    return s[FRAC_W+IDX_W-1:FRAC_W];
  endfunction

endpackage

@@ hw/rtl/bgi_mulq.sv @@
// Three-stage Q16.16 product floor(a*b/2^16) with 64-bit saturation.
// Built from four registered 32x32 partial products. Depends on bgi_pkg.
module bgi_mulq (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg_a;
  logic [63:0]  pp_ll;
  logic [63:0]  pp_lh;
  logic [63:0]  pp_hl;
  logic [63:0]  pp_hh;
  logic         neg_b;
  logic [127:0] sum;
  logic [48:0]  mag;

  always_ff @(posedge clk) begin
    ua    <= a[63] ? 64'(-a) : 64'(a);
    ub    <= b[63] ? 64'(-b) : 64'(b);
    neg_a <= a[63] ^ b[63];
  end

  always_ff @(posedge clk) begin
    pp_ll <= ua[31:0]  * ub[31:0];
    pp_lh <= ua[31:0]  * ub[63:32];
    pp_hl <= ua[63:32] * ub[31:0];
    pp_hh <= ua[63:32] * ub[63:32];
    neg_b <= neg_a;
  end

  always_comb begin
    sum = {pp_hh, pp_ll} + ({64'h0, pp_lh} << 32) + ({64'h0, pp_hl} << 32);
    // round the magnitude up on a negative result so the floor holds
    mag = {1'b0, sum[63:16]} + 49'(neg_b && (sum[15:0] != 16'h0));
  end

  always_ff @(posedge clk) begin
    if (sum[127:64] != 64'h0) begin
      p <= neg_b ? bgi_pkg::S64_MIN : bgi_pkg::S64_MAX;
    end else if (neg_b) begin
      p <= -$signed({15'h0, mag});
    end else begin
      p <= $signed({16'h0, sum[63:16]});
    end
  end

endmodule

@@ hw/rtl/bgi_front.sv @@
// Front end: accepts transactions, scales points to grid position, finds
// the cell and fractions, and queues the work. Depends on bgi_pkg, bgi_mulq.
module bgi_front (
  input  logic                      clk,
  input  logic                      rst,
  input  bgi_pkg::cfg_t             cfg,
  input  logic                      push,
  output logic                      full,
  input  logic                      operation,
  input  logic [bgi_pkg::ROW_W-1:0] row_index,
  input  logic [bgi_pkg::COL_W-1:0] column_index,
  input  logic signed [31:0]        sample_value,
  input  logic signed [31:0]        point_first,
  input  logic signed [31:0]        point_second,
  output bgi_pkg::item_t            item,
  output logic                      item_valid,
  input  logic                      item_pop
);

  logic [bgi_pkg::Q_CNT_W-1:0]  occ;
  logic                         accept;
  logic                         v0;
  bgi_pkg::item_t               it0;
  logic signed [31:0]           p1_0;
  logic signed [31:0]           p2_0;
  logic signed [32:0]           diff1;
  logic signed [32:0]           diff2;
  logic signed [63:0]           s1;
  logic signed [63:0]           s2;
  logic [bgi_pkg::MULQ_LAT-1:0] vd;
  bgi_pkg::item_t               itd [bgi_pkg::MULQ_LAT];
  logic [bgi_pkg::IDX_W-1:0]    ci;
  logic [bgi_pkg::IDX_W-1:0]    cj;
  logic                         v4;
  bgi_pkg::item_t               it4;
  bgi_pkg::item_t               q [bgi_pkg::Q_DEPTH];
  logic [bgi_pkg::Q_PTR_W-1:0]  wptr;
  logic [bgi_pkg::Q_PTR_W-1:0]  rptr;
  logic [bgi_pkg::Q_CNT_W-1:0]  qcnt;

  // Credit covers the whole front pipeline plus the queue, so the queue never overflows.
  assign full   = (occ == bgi_pkg::Q_CNT_W'(bgi_pkg::Q_DEPTH));
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + bgi_pkg::Q_CNT_W'(accept) - bgi_pkg::Q_CNT_W'(item_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      vd <= '0;
      v4 <= 1'b0;
    end else begin
      v0 <= accept;
      vd <= {vd[bgi_pkg::MULQ_LAT-2:0], v0};
      v4 <= vd[bgi_pkg::MULQ_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it0.eval   <= operation;
      it0.row    <= row_index;
      it0.col    <= column_index;
      it0.sample <= sample_value;
      it0.t      <= '0;
      it0.u      <= '0;
      p1_0       <= point_first;
      p2_0       <= point_second;
    end
  end

  assign diff1 = {p1_0[31], p1_0} - {cfg.org1[31], cfg.org1};
  assign diff2 = {p2_0[31], p2_0} - {cfg.org2[31], cfg.org2};

  bgi_mulq u_pos1 (
    .clk (clk),
    .a   ({{31{diff1[32]}}, diff1}),
    .b   ({32'h0, cfg.inv1}),
    .p   (s1)
  );

  bgi_mulq u_pos2 (
    .clk (clk),
    .a   ({{31{diff2[32]}}, diff2}),
    .b   ({32'h0, cfg.inv2}),
    .p   (s2)
  );

  always_ff @(posedge clk) begin
    itd[0] <= it0;
    for (int k = 1; k < bgi_pkg::MULQ_LAT; k++) begin
      itd[k] <= itd[k-1];
    end
  end

  assign ci = bgi_pkg::cell_index(s1, bgi_pkg::clamp_points(cfg.pts1,
              bgi_pkg::PTS_W'(bgi_pkg::MAX_FIRST_POINTS)));
  assign cj = bgi_pkg::cell_index(s2, bgi_pkg::clamp_points(cfg.pts2,
              bgi_pkg::PTS_W'(bgi_pkg::MAX_SECOND_POINTS)));

  always_ff @(posedge clk) begin
    it4.eval   <= itd[bgi_pkg::MULQ_LAT-1].eval;
    it4.sample <= itd[bgi_pkg::MULQ_LAT-1].sample;
    it4.t      <= s1 - (64'(ci) << bgi_pkg::FRAC_W);
    it4.u      <= s2 - (64'(cj) << bgi_pkg::FRAC_W);
    if (itd[bgi_pkg::MULQ_LAT-1].eval == bgi_pkg::OP_EVAL) begin
      it4.row <= bgi_pkg::ROW_W'(ci);
      it4.col <= bgi_pkg::COL_W'(cj);
    end else begin
      it4.row <= itd[bgi_pkg::MULQ_LAT-1].row;
      it4.col <= itd[bgi_pkg::MULQ_LAT-1].col;
    end
  end

  always_ff @(posedge clk) begin
    if (v4) begin
      q[wptr] <= it4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      qcnt <= '0;
    end else begin
      wptr <= wptr + bgi_pkg::Q_PTR_W'(v4);
      rptr <= rptr + bgi_pkg::Q_PTR_W'(item_pop);
      qcnt <= qcnt + bgi_pkg::Q_CNT_W'(v4) - bgi_pkg::Q_CNT_W'(item_pop);
    end
  end

  assign item       = q[rptr];
  assign item_valid = (qcnt != '0);

endmodule

@@ hw/rtl/bgi_back.sv @@
// Back end: pops queued work, writes or reads the banked sample table,
// runs the bilinear arithmetic and holds results. Depends on bgi_pkg, bgi_mulq.
module bgi_back (
  input  logic               clk,
  input  logic               rst,
  input  bgi_pkg::cfg_t      cfg,
  input  bgi_pkg::item_t     item,
  input  logic               item_valid,
  output logic               item_pop,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] interpolated_value,
  output logic signed [31:0] slope_first,
  output logic signed [31:0] slope_second
);

  typedef struct packed {
    logic signed [63:0] y00;
    logic signed [63:0] y01;
    logic signed [63:0] d0;
    logic signed [63:0] e0;
    logic signed [63:0] u;
  } l1_t;

  logic [bgi_pkg::OUT_CNT_W-1:0] ocred;
  logic                          out_take;
  logic [31:0]                   rdata [bgi_pkg::NUM_BANKS];
  logic                          v1;
  logic                          i0;
  logic                          j0;
  logic signed [63:0]            t1;
  logic signed [63:0]            u1;
  logic signed [63:0]            y00;
  logic signed [63:0]            y10;
  logic signed [63:0]            y01;
  logic signed [63:0]            y11;
  logic                          v2;
  l1_t                           l2;
  logic signed [63:0]            t2;
  logic signed [63:0]            d1_2;
  logic signed [63:0]            dd2;
  logic signed [63:0]            de2;
  logic signed [63:0]            m0;
  logic signed [63:0]            m1;
  logic signed [63:0]            m2;
  logic signed [63:0]            m3;
  logic [bgi_pkg::MULQ_LAT-1:0]  vd1;
  l1_t                           l1d [bgi_pkg::MULQ_LAT];
  logic                          v6;
  logic signed [63:0]            a6;
  logic signed [63:0]            b6;
  logic signed [63:0]            ga6;
  logic signed [63:0]            ha6;
  logic signed [63:0]            u6;
  logic signed [63:0]            mv;
  logic signed [63:0]            g9;
  logic signed [63:0]            h9;
  logic [bgi_pkg::MULQ_LAT-1:0]  vd2;
  logic signed [63:0]            ad [bgi_pkg::MULQ_LAT];
  bgi_pkg::result_t              res;
  bgi_pkg::result_t              ofifo [bgi_pkg::OUT_DEPTH];
  logic [bgi_pkg::OUT_PTR_W-1:0] owptr;
  logic [bgi_pkg::OUT_PTR_W-1:0] orptr;
  logic [bgi_pkg::OUT_CNT_W-1:0] ocnt;
  logic                          owr;

  // Loads never need result space; evaluates reserve a result slot when popped.
  assign item_pop = item_valid &&
                    (!item.eval || (ocred != bgi_pkg::OUT_CNT_W'(bgi_pkg::OUT_DEPTH)));
  assign out_take = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      ocred <= '0;
    end else begin
      ocred <= ocred + bgi_pkg::OUT_CNT_W'(item_pop && item.eval)
                     - bgi_pkg::OUT_CNT_W'(out_take);
    end
  end

  // Four banks by row and column parity: any 2x2 cell hits each bank once.
  for (genvar k = 0; k < bgi_pkg::NUM_BANKS; k++) begin : g_bank
    localparam logic PR = 1'((k >> 1) & 1);
    localparam logic PC = 1'(k & 1);
    logic [31:0]                 mem [bgi_pkg::BANK_DEPTH];
    logic [31:0]                 rd;
    logic [bgi_pkg::ROW_W-1:0]   rsel;
    logic [bgi_pkg::COL_W-1:0]   csel;
    logic                        we;

    assign rsel = item.row + bgi_pkg::ROW_W'(item.row[0] ^ PR);
    assign csel = item.col + bgi_pkg::COL_W'(item.col[0] ^ PC);
    assign we   = item_pop && (item.eval == bgi_pkg::OP_LOAD) &&
                  (item.row[0] == PR) && (item.col[0] == PC);

    always_ff @(posedge clk) begin
      if (we) begin
        mem[{item.row[bgi_pkg::ROW_W-1:1], item.col[bgi_pkg::COL_W-1:1]}] <= item.sample;
      end
      rd <= mem[{rsel[bgi_pkg::ROW_W-1:1], csel[bgi_pkg::COL_W-1:1]}];
    end

    assign rdata[k] = rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      vd1 <= '0;
      v6  <= 1'b0;
      vd2 <= '0;
    end else begin
      v1  <= item_pop && (item.eval == bgi_pkg::OP_EVAL);
      v2  <= v1;
      vd1 <= {vd1[bgi_pkg::MULQ_LAT-2:0], v2};
      v6  <= vd1[bgi_pkg::MULQ_LAT-1];
      vd2 <= {vd2[bgi_pkg::MULQ_LAT-2:0], v6};
    end
  end

  always_ff @(posedge clk) begin
    i0 <= item.row[0];
    j0 <= item.col[0];
    t1 <= item.t;
    u1 <= item.u;
  end

  // Steer bank outputs to cell corners by the parity of the lower-left index.
  always_comb begin
    y00 = {{32{rdata[{i0, j0}][31]}},   rdata[{i0, j0}]};
    y10 = {{32{rdata[{~i0, j0}][31]}},  rdata[{~i0, j0}]};
    y01 = {{32{rdata[{i0, ~j0}][31]}},  rdata[{i0, ~j0}]};
    y11 = {{32{rdata[{~i0, ~j0}][31]}}, rdata[{~i0, ~j0}]};
  end

  always_ff @(posedge clk) begin
    l2.y00 <= y00;
    l2.y01 <= y01;
    l2.d0  <= y10 - y00;
    l2.e0  <= y01 - y00;
    l2.u   <= u1;
    t2     <= t1;
    d1_2   <= y11 - y01;
    dd2    <= (y11 - y01) - (y10 - y00);
    de2    <= (y11 - y10) - (y01 - y00);
  end

  bgi_mulq u_ma (.clk(clk), .a(t2),   .b(l2.d0), .p(m0));
  bgi_mulq u_mb (.clk(clk), .a(t2),   .b(d1_2),  .p(m1));
  bgi_mulq u_mg (.clk(clk), .a(l2.u), .b(dd2),   .p(m2));
  bgi_mulq u_mh (.clk(clk), .a(t2),   .b(de2),   .p(m3));

  always_ff @(posedge clk) begin
    l1d[0] <= l2;
    for (int k = 1; k < bgi_pkg::MULQ_LAT; k++) begin
      l1d[k] <= l1d[k-1];
    end
  end

  always_ff @(posedge clk) begin
    a6  <= bgi_pkg::sadd64(l1d[bgi_pkg::MULQ_LAT-1].y00, m0);
    b6  <= bgi_pkg::sadd64(l1d[bgi_pkg::MULQ_LAT-1].y01, m1);
    ga6 <= bgi_pkg::sadd64(l1d[bgi_pkg::MULQ_LAT-1].d0,  m2);
    ha6 <= bgi_pkg::sadd64(l1d[bgi_pkg::MULQ_LAT-1].e0,  m3);
    u6  <= l1d[bgi_pkg::MULQ_LAT-1].u;
  end

  bgi_mulq u_mv (.clk(clk), .a(u6),  .b(bgi_pkg::ssub64(b6, a6)), .p(mv));
  bgi_mulq u_mx (.clk(clk), .a(ga6), .b({32'h0, cfg.inv1}),      .p(g9));
  bgi_mulq u_my (.clk(clk), .a(ha6), .b({32'h0, cfg.inv2}),      .p(h9));

  always_ff @(posedge clk) begin
    ad[0] <= a6;
    for (int k = 1; k < bgi_pkg::MULQ_LAT; k++) begin
      ad[k] <= ad[k-1];
    end
  end

  always_comb begin
    owr        = vd2[bgi_pkg::MULQ_LAT-1];
    res.value  = bgi_pkg::sat32(bgi_pkg::sadd64(ad[bgi_pkg::MULQ_LAT-1], mv));
    res.slope1 = bgi_pkg::sat32(g9);
    res.slope2 = bgi_pkg::sat32(h9);
  end

  always_ff @(posedge clk) begin
    if (owr) begin
      ofifo[owptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr <= '0;
      orptr <= '0;
      ocnt  <= '0;
    end else begin
      owptr <= owptr + bgi_pkg::OUT_PTR_W'(owr);
      orptr <= orptr + bgi_pkg::OUT_PTR_W'(out_take);
      ocnt  <= ocnt + bgi_pkg::OUT_CNT_W'(owr) - bgi_pkg::OUT_CNT_W'(out_take);
    end
  end

  assign empty              = (ocnt == '0);
  assign interpolated_value = ofifo[orptr].value;
  assign slope_first        = ofifo[orptr].slope1;
  assign slope_second       = ofifo[orptr].slope2;

endmodule

@@ hw/rtl/bilinear_grid_interpolator_unit.sv @@
// Top level of the bilinear grid interpolator: configuration registers,
// front end, back end and checks. Depends on bgi_pkg, bgi_front, bgi_back.
//
//   channel   direction  handshake             payload
//   input     in         push / full           operation, row_index, column_index,
//                                              sample_value, point_first, point_second
//   result    out        empty / pop           interpolated_value, slope_first, slope_second
//   config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction per cycle is taken in steady state while full is low. Each one passes
// the front (input register, 3-stage position multiply, index stage); an evaluate then
// passes the back (bank read, difference register, two 3-stage multiply layers split
// by a sum register). The 8-entry work queue and 16-entry result queue set how far
// each side runs on while the other stalls. Loads produce no result and need no result space.
// Reset (synchronous, active high) clears control state and restores the
// register defaults; the sample table holds garbage until loaded.
module bilinear_grid_interpolator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               operation,
  input  logic [bgi_pkg::ROW_W-1:0]          row_index,
  input  logic [bgi_pkg::COL_W-1:0]          column_index,
  input  logic signed [31:0]                 sample_value,
  input  logic signed [31:0]                 point_first,
  input  logic signed [31:0]                 point_second,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [31:0]                 interpolated_value,
  output logic signed [31:0]                 slope_first,
  output logic signed [31:0]                 slope_second,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data
);

  bgi_pkg::cfg_t  cfg;
  bgi_pkg::item_t item;
  logic           item_valid;
  logic           item_pop;

  // Register writes take effect in the cycle after they are offered, so the port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.org1 <= '0;
      cfg.org2 <= '0;
      cfg.inv1 <= 32'h0001_0000;
      cfg.inv2 <= 32'h0001_0000;
      cfg.pts1 <= bgi_pkg::PTS_W'(64);
      cfg.pts2 <= bgi_pkg::PTS_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bgi_pkg::REG_FIRST_ORIGIN:  cfg.org1 <= cfg_data;
        bgi_pkg::REG_SECOND_ORIGIN: cfg.org2 <= cfg_data;
        bgi_pkg::REG_FIRST_INV:     cfg.inv1 <= cfg_data;
        bgi_pkg::REG_SECOND_INV:    cfg.inv2 <= cfg_data;
        bgi_pkg::REG_FIRST_POINTS:  cfg.pts1 <= cfg_data[bgi_pkg::PTS_W-1:0];
        bgi_pkg::REG_SECOND_POINTS: cfg.pts2 <= cfg_data[bgi_pkg::PTS_W-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Front end: classify and place each transaction on the grid.
  bgi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .row_index    (row_index),
    .column_index (column_index),
    .sample_value (sample_value),
    .point_first  (point_first),
    .point_second (point_second),
    .item         (item),
    .item_valid   (item_valid),
    .item_pop     (item_pop)
  );

  // Back end: table access, interpolation and result queue.
  bgi_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .item               (item),
    .item_valid         (item_valid),
    .item_pop           (item_pop),
    .empty              (empty),
    .pop                (pop),
    .interpolated_value (interpolated_value),
    .slope_first        (slope_first),
    .slope_second       (slope_second)
  );

  // Back end only pops queued work.
  a_pop_needs_work: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> item_valid)
    else $error("back end popped an empty work queue");

  // Queued work stays until the back end takes it.
  a_work_holds: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_pop) |=> item_valid)
    else $error("queued work vanished without a pop");

  // Nothing is waiting on the first cycle out of reset.
  a_reset_clears: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (empty && !item_valid))
    else $error("queues not empty after reset");

endmodule

@@ bench/bilinear_grid_interpolator_unit_test.sv @@
// Self-checking testbench for bilinear_grid_interpolator_unit: a scoreboard class
// predicts value and slopes for every accepted evaluate transaction.
// Depends on bgi_pkg and the block's RTL.
`timescale 1ns / 1ps

module bilinear_grid_interpolator_unit_test;

  localparam int DRAIN_CYCLES = 40;   // well past the pipeline depth
  localparam int FILL_SIDE = 16;      // square corner of the table that is fully loaded
  localparam longint Q1 = 64'sd65536;
  localparam longint L_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint L_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic        op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] sample;
    logic [31:0] pf;
    logic [31:0] ps;
  } grid_txn_t;

  // Q16.16 product, floored, saturated at 64 bits.
  function automatic longint fixmul(longint a, longint b);
    logic [63:0]  ma, mb;
    logic [127:0] p;
    bit           neg;
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    p   = {64'b0, ma} * {64'b0, mb};
    if (p[127:64] != 0) return neg ? L_MIN : L_MAX;
    if (!neg) return longint'(p[63:16]);
    return -longint'(p[63:16]) - longint'(p[15:0] != 0);
  endfunction

  function automatic longint sum_sat(longint a, longint b);
    logic signed [64:0] s;
    s = a;
    s = s + b;
    if (s[64] != s[63]) return s[64] ? L_MIN : L_MAX;
    return s[63:0];
  endfunction

  function automatic longint diff_sat(longint a, longint b);
    logic signed [64:0] s;
    s = a;
    s = s - b;
    if (s[64] != s[63]) return s[64] ? L_MIN : L_MAX;
    return s[63:0];
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint lower_corner(longint s, int n);
    longint i;
    i = (s < 0) ? 0 : (s >>> 16);
    if (i > n - 2) i = n - 2;
    return i;
  endfunction

  class grid_scoreboard;
    longint           org1, org2, inv1, inv2;
    int               pts1, pts2;
    logic [31:0]      grid [64][64];
    bgi_pkg::result_t pending_results[$];
    int               errors;

    function void restore_defaults();
      org1 = 0; org2 = 0; inv1 = Q1; inv2 = Q1; pts1 = 64; pts2 = 64;
    endfunction

    function void set_register(logic [bgi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        bgi_pkg::REG_FIRST_ORIGIN:  org1 = longint'(signed'(d));
        bgi_pkg::REG_SECOND_ORIGIN: org2 = longint'(signed'(d));
        bgi_pkg::REG_FIRST_INV:     inv1 = longint'({32'b0, d});
        bgi_pkg::REG_SECOND_INV:    inv2 = longint'({32'b0, d});
        bgi_pkg::REG_FIRST_POINTS:  pts1 = int'(d[6:0]);
        bgi_pkg::REG_SECOND_POINTS: pts2 = int'(d[6:0]);
        default: ;
      endcase
    endfunction

    function int used_points(int n);
      if (n < 2) return 2;
      return (n > 64) ? 64 : n;
    endfunction

    // Note an accepted transaction: loads update the table, evaluates queue a result.
    function void note_input(grid_txn_t x);
      longint           s1, s2, i, j, t, u, y00, y10, y01, y11, a, b, d0, d1, e0, e1;
      bgi_pkg::result_t r;
      if (x.op == bgi_pkg::OP_LOAD) begin
        grid[x.row][x.col] = x.sample;
        return;
      end
      s1 = fixmul(longint'(signed'(x.pf)) - org1, inv1);
      s2 = fixmul(longint'(signed'(x.ps)) - org2, inv2);
      i = lower_corner(s1, used_points(pts1));
      j = lower_corner(s2, used_points(pts2));
      t = s1 - i * Q1;
      u = s2 - j * Q1;
      y00 = longint'(signed'(grid[i][j]));
      y10 = longint'(signed'(grid[i+1][j]));
      y01 = longint'(signed'(grid[i][j+1]));
      y11 = longint'(signed'(grid[i+1][j+1]));
      a = sum_sat(y00, fixmul(t, y10 - y00));
      b = sum_sat(y01, fixmul(t, y11 - y01));
      d0 = y10 - y00; d1 = y11 - y01;
      e0 = y01 - y00; e1 = y11 - y10;
      r.value  = clip32(sum_sat(a, fixmul(u, diff_sat(b, a))));
      r.slope1 = clip32(fixmul(sum_sat(d0, fixmul(u, d1 - d0)), inv1));
      r.slope2 = clip32(fixmul(sum_sat(e0, fixmul(t, e1 - e0)), inv2));
      pending_results.push_back(r);
    endfunction

    function void check_result(bgi_pkg::result_t got);
      bgi_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no evaluate outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.value !== want.value) begin
        $error("interpolated_value expected %0d got %0d", want.value, got.value);
        errors++;
      end
      if (got.slope1 !== want.slope1) begin
        $error("slope_first expected %0d got %0d", want.slope1, got.slope1);
        errors++;
      end
      if (got.slope2 !== want.slope2) begin
        $error("slope_second expected %0d got %0d", want.slope2, got.slope2);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0, pop = 1'b0;
  logic full, empty;
  logic operation = bgi_pkg::OP_LOAD;
  logic [bgi_pkg::ROW_W-1:0] row_index = '0;
  logic [bgi_pkg::COL_W-1:0] column_index = '0;
  logic signed [31:0] sample_value = '0, point_first = '0, point_second = '0;
  logic signed [31:0] interpolated_value, slope_first, slope_second;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bgi_pkg::CFG_IDX_W-1:0] cfg_index = bgi_pkg::REG_FIRST_ORIGIN;
  logic [31:0] cfg_data = '0;

  grid_scoreboard sb = new();
  bit quiet = 1'b0;   // no idling on either side once set

  bilinear_grid_interpolator_unit dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: take results in order, stall pop in random bursts.
  initial begin
    int stall_left;
    bgi_pkg::result_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got.value = interpolated_value;
        got.slope1 = slope_first;
        got.slope2 = slope_second;
        sb.check_result(got);
      end
      if (stall_left > 0) stall_left--;
      else if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      pop <= (stall_left == 0);
    end
  end

  // Drive one transaction and hold it until accepted; maybe idle afterward.
  task automatic send(grid_txn_t x);
    int gap;
    push <= 1'b1;
    operation <= x.op;
    row_index <= x.row;
    column_index <= x.col;
    sample_value <= x.sample;
    point_first <= x.pf;
    point_second <= x.ps;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(x);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Release the input, wait out every expected result, then let loads settle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [bgi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load(int r, int c, logic [31:0] v);
    grid_txn_t x;
    x.op = bgi_pkg::OP_LOAD; x.row = 6'(r); x.col = 6'(c); x.sample = v;
    x.pf = $urandom; x.ps = $urandom;
    send(x);
  endtask

  task automatic evaluate(logic [31:0] p1, logic [31:0] p2);
    grid_txn_t x;
    x.op = bgi_pkg::OP_EVAL; x.row = 6'($urandom); x.col = 6'($urandom);
    x.sample = $urandom;
    x.pf = p1; x.ps = p2;
    send(x);
  endtask

  function automatic logic [31:0] any_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 1 << 20) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // Point near the grid: up to two cells beyond either edge, at any fraction.
  function automatic logic [31:0] near_point(longint org, longint inv, int n);
    longint g;
    if (inv == 0) return $urandom;
    g = longint'($urandom_range(0, (n + 3) * 65536)) - 2 * Q1;
    return 32'(org + (g * Q1) / inv);
  endfunction

  task automatic configure(longint o1, longint o2, logic [31:0] v1, logic [31:0] v2,
                           logic [6:0] n1, logic [6:0] n2);
    write_reg(bgi_pkg::REG_FIRST_ORIGIN, o1[31:0]);
    write_reg(bgi_pkg::REG_SECOND_ORIGIN, o2[31:0]);
    write_reg(bgi_pkg::REG_FIRST_INV, v1);
    write_reg(bgi_pkg::REG_SECOND_INV, v2);
    write_reg(bgi_pkg::REG_FIRST_POINTS, {25'b0, n1});
    write_reg(bgi_pkg::REG_SECOND_POINTS, {25'b0, n2});
  endtask

  initial begin
    sb.restore_defaults();
    sb.errors = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load the low square corner and the first two rows and columns in full.
    // Every setting below keeps evaluates inside that loaded region: at most
    // FILL_SIDE points on both axes, or up to 64 on one axis with 2 on the other.
    for (int r = 0; r < 64; r++)
      for (int c = 0; c < 64; c++)
        if ((r < FILL_SIDE && c < FILL_SIDE) || r < 2 || c < 2)
          load(r, c, any_sample());

    // Directed: extreme samples in the corner cells, then edge and far-out points.
    load(0, 0, 32'h7FFF_FFFF);
    load(1, 0, 32'h8000_0000);
    load(0, 1, 32'h8000_0000);
    load(1, 1, 32'h7FFF_FFFF);
    load(FILL_SIDE - 1, FILL_SIDE - 1, 32'h8000_0000);
    load(FILL_SIDE - 2, FILL_SIDE - 1, 32'h7FFF_FFFF);
    drain();
    configure(0, 0, 32'h0001_0000, 32'h0001_0000, 7'(FILL_SIDE), 7'(FILL_SIDE));
    evaluate(32'h0000_0000, 32'h0000_0000);
    evaluate(32'h0000_8000, 32'h0000_4000);
    evaluate(32'h003F_0000, 32'h003F_0000);
    evaluate(32'h000E_C000, 32'h000E_2000);
    evaluate(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    evaluate(32'h8000_0000, 32'h8000_0000);
    evaluate(32'h7FFF_FFFF, 32'h8000_0000);
    evaluate(32'hFFFF_FFFF, 32'h0001_0000);
    drain();
    // Zero inverse step and out-of-range point counts.
    configure(0, 0, 32'h0, 32'h0, 7'd0, 7'd1);
    evaluate(32'h1234_5678, 32'h8765_4321);
    evaluate(32'h0000_0000, 32'h7FFF_FFFF);
    drain();
    configure(-64'sd2147483648, 64'sd2147483647, 32'h1, 32'hFFFF_FFFF, 7'd127, 7'd1);
    evaluate(32'h8000_0000, 32'h7FFF_FFFF);
    evaluate(32'h7FFF_FFFF, 32'h8000_0000);
    evaluate(32'h0000_0000, 32'h0000_0000);
    drain();

    // Random phases: new settings, a batch of loads, then mostly near-grid evaluates.
    for (int k = 0; k < 8; k++) begin
      case (k)
        0: configure(0, 0, 32'h0001_0000, 32'h0001_0000, 7'd64, 7'd2);
        1: configure(-64'sd2147483648, 64'sd2147483647, 32'hFFFF_FFFF, 32'h1, 7'd2, 7'd2);
        2: configure(64'sd2147483647, -64'sd2147483648, 32'h1, 32'hFFFF_FFFF, 7'd2, 7'd64);
        3: configure(0, 0, 32'h0, 32'h0001_0000, 7'd127, 7'd1);
        default: configure(longint'(signed'($urandom)), longint'(signed'($urandom)),
                           $urandom_range(1 << 12, 1 << 20), $urandom_range(1 << 12, 1 << 20),
                           7'($urandom_range(2, FILL_SIDE)),
                           7'($urandom_range(2, FILL_SIDE)));
      endcase
      if (k == 7) quiet = 1'b1;
      for (int n = 0; n < 24; n++)
        load($urandom_range(0, 63), $urandom_range(0, 63), any_sample());
      drain();
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 3) == 0) evaluate($urandom, $urandom);
        else evaluate(near_point(sb.org1, sb.inv1, sb.used_points(sb.pts1)),
                      near_point(sb.org2, sb.inv2, sb.used_points(sb.pts2)));
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
